>>> rtl/tpfm_pkg.sv
// ----------------------------------------------------------------------------
// tpfm_pkg
// Shared types and constants for the tire pressure frame monitor: payload
// structs, register indexes, reset values and scaling constants.
// ----------------------------------------------------------------------------
package tpfm_pkg;

	// Default number of monitored wheels
	localparam int WHEEL_COUNT_DEF = 4;

	// Configuration port
	localparam int CFG_W     = 29;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ID      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPORT_PERIOD = 2'd2;

	localparam logic [28:0] FRAME_ID_RST      = 29'h18FE_F433;
	localparam logic [15:0] TIMEOUT_RST       = 16'd2000;
	localparam logic [15:0] REPORT_PERIOD_RST = 16'd200;

	// Counter and age ceiling
	localparam logic [15:0] AGE_MAX = 16'hFFFF;

	// Scaling: pressure raw*101+3500 (0.0001 bar), battery byte*1237 (0.1 mV)
	localparam logic [22:0] PRESS_SCALE  = 23'd101;
	localparam logic [22:0] PRESS_OFFSET = 23'd3500;
	localparam logic [18:0] BATT_SCALE   = 19'd1237;

	// Input item kinds
	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [28:0] frame_ident;
		logic [7:0]  wheel_byte;
		logic [7:0]  pressure_high;
		logic [7:0]  pressure_low;
		logic [7:0]  temp_byte;
		logic [7:0]  battery_byte;
		logic [7:0]  flag_byte;
	} tpfm_in_t;

	typedef struct packed {
		logic [2:0]  wheel;
		logic        online;
		logic [22:0] pressure_tenth_mbar;
		logic [7:0]  temperature;
		logic [18:0] battery_tenth_mv;
		logic        leak_alert;
		logic        heat_alert;
		logic        last;
	} tpfm_out_t;

endpackage

>>> rtl/tire_pressure_frame_monitor_unit.sv
// ----------------------------------------------------------------------------
// tire_pressure_frame_monitor_unit
// Each input item (frame or tick) passes through the input register stage.
// A reporting tick snapshots all wheels; results then leave one per cycle
// while out_stall is low, WHEEL_COUNT results per report.
// Ticks are held in the input stage while a report drains; frames are not.
// Asynchronous active-low reset: wheels unheard, ages and counter zero,
// registers at their defaults.
// ----------------------------------------------------------------------------
module tire_pressure_frame_monitor_unit #(
	parameter int WHEEL_COUNT = tpfm_pkg::WHEEL_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  tpfm_pkg::tpfm_in_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output tpfm_pkg::tpfm_out_t            out_data,
	input  logic                           cfg_we,
	input  logic [tpfm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tpfm_pkg::CFG_W-1:0]     cfg_data
);
	import tpfm_pkg::*;

	localparam int IDX_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WHEEL_COUNT - 1);

	// Configuration registers
	logic [28:0] frame_id_q;
	logic [15:0] timeout_q;
	logic [15:0] period_q;

	// Input stage
	logic     s1_valid;
	tpfm_in_t s1_data;
	logic     s1_go;

	// Per-wheel state
	logic [15:0] press_q [WHEEL_COUNT];
	logic [7:0]  temp_q  [WHEEL_COUNT];
	logic [7:0]  batt_q  [WHEEL_COUNT];
	logic [1:0]  alert_q [WHEEL_COUNT];
	logic [15:0] age_q   [WHEEL_COUNT];
	logic [15:0] age_inc [WHEEL_COUNT];
	logic        seen_q  [WHEEL_COUNT];
	logic [15:0] rcnt_q;
	logic [15:0] rcnt_inc;

	// Report snapshot and drain control
	logic [15:0]      snp_press_q  [WHEEL_COUNT];
	logic [7:0]       snp_temp_q   [WHEEL_COUNT];
	logic [7:0]       snp_batt_q   [WHEEL_COUNT];
	logic [1:0]       snp_alert_q  [WHEEL_COUNT];
	logic             snp_online_q [WHEEL_COUNT];
	logic             rpt_busy_q;
	logic [IDX_W-1:0] rpt_idx_q;

	logic      s1_tick;
	logic      s1_frame_hit;
	logic      rpt_fire;
	logic      out_load;
	logic      out_valid_q;
	tpfm_out_t out_data_q;
	tpfm_out_t out_next;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_id_q <= FRAME_ID_RST;
			timeout_q  <= TIMEOUT_RST;
			period_q   <= REPORT_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_ID:      frame_id_q <= cfg_data[28:0];
				REG_TIMEOUT_MS:    timeout_q  <= cfg_data[15:0];
				REG_REPORT_PERIOD: period_q   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Hold a tick in the input stage while a report drains
	assign s1_tick  = s1_valid && (s1_data.kind == KIND_TICK);
	assign s1_go    = s1_valid && !(s1_tick && rpt_busy_q);
	assign in_stall = s1_valid && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!in_stall) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			s1_data <= in_data;
		end
	end

	// Saturating increments for ages and the report counter
	always_comb begin
		for (int i = 0; i < WHEEL_COUNT; i++) begin
			age_inc[i] = (age_q[i] == AGE_MAX) ? age_q[i] : age_q[i] + 16'd1;
		end
		rcnt_inc = (rcnt_q == AGE_MAX) ? rcnt_q : rcnt_q + 16'd1;
	end

	assign s1_frame_hit = s1_go && (s1_data.kind == KIND_FRAME)
	                      && (s1_data.frame_ident == frame_id_q)
	                      && (s1_data.wheel_byte != 8'd0)
	                      && (s1_data.wheel_byte <= 8'(WHEEL_COUNT));
	assign rpt_fire     = s1_go && s1_tick && (rcnt_inc >= period_q);

	// Update wheel control state: restart age on a matching frame, age on a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				age_q[i]  <= '0;
				seen_q[i] <= 1'b0;
			end
			rcnt_q <= '0;
		end else if (s1_go) begin
			if (s1_tick) begin
				for (int i = 0; i < WHEEL_COUNT; i++) begin
					age_q[i] <= age_inc[i];
				end
				rcnt_q <= rpt_fire ? 16'd0 : rcnt_inc;
			end else if (s1_frame_hit) begin
				for (int i = 0; i < WHEEL_COUNT; i++) begin
					if (s1_data.wheel_byte == 8'(i + 1)) begin
						age_q[i]  <= '0;
						seen_q[i] <= 1'b1;
					end
				end
			end
		end
	end

	// Store sensor values of a matching frame
	always_ff @(posedge clk) begin
		if (s1_frame_hit) begin
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				if (s1_data.wheel_byte == 8'(i + 1)) begin
					press_q[i] <= {s1_data.pressure_high, s1_data.pressure_low};
					temp_q[i]  <= s1_data.temp_byte;
					batt_q[i]  <= s1_data.battery_byte;
					alert_q[i] <= {s1_data.flag_byte[4], s1_data.flag_byte[0]};
				end
			end
		end
	end

	// Snapshot all wheels on a reporting tick, using the aged values
	always_ff @(posedge clk) begin
		if (rpt_fire) begin
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				snp_press_q[i]  <= press_q[i];
				snp_temp_q[i]   <= temp_q[i];
				snp_batt_q[i]   <= batt_q[i];
				snp_alert_q[i]  <= alert_q[i];
				snp_online_q[i] <= seen_q[i] && (age_inc[i] <= timeout_q);
			end
		end
	end

	// Advance through the snapshot one wheel per transfer slot
	assign out_load = rpt_busy_q && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_busy_q <= 1'b0;
			rpt_idx_q  <= '0;
		end else if (rpt_fire) begin
			rpt_busy_q <= 1'b1;
			rpt_idx_q  <= '0;
		end else if (out_load) begin
			if (rpt_idx_q == IDX_LAST) begin
				rpt_busy_q <= 1'b0;
				rpt_idx_q  <= '0;
			end else begin
				rpt_idx_q <= rpt_idx_q + IDX_W'(1);
			end
		end
	end

	// Scale the selected wheel; drop the values of an offline wheel
	always_comb begin
		logic on;
		on = snp_online_q[rpt_idx_q];
		out_next.wheel  = 3'({1'b0, rpt_idx_q}) + 3'd1;
		out_next.online = on;
		out_next.pressure_tenth_mbar = on ? (23'(snp_press_q[rpt_idx_q]) * PRESS_SCALE
		                                     + PRESS_OFFSET) : 23'd0;
		out_next.temperature      = on ? snp_temp_q[rpt_idx_q] : 8'd0;
		out_next.battery_tenth_mv = on ? (19'(snp_batt_q[rpt_idx_q]) * BATT_SCALE) : 19'd0;
		out_next.leak_alert       = on && snp_alert_q[rpt_idx_q][0];
		out_next.heat_alert       = on && snp_alert_q[rpt_idx_q][1];
		out_next.last             = (rpt_idx_q == IDX_LAST);
	end

	// Output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef NO_ASSERTIONS
	// A reporting tick never lands while the snapshot still drains
	a_no_fire_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_fire |-> !rpt_busy_q)
		else $error("report fired while previous report draining");

	// A reporting tick starts a drain in the next cycle
	a_fire_starts: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_fire |=> (rpt_busy_q && rpt_idx_q == '0))
		else $error("report drain did not start");

	// An idle drain sits at the first wheel
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!rpt_busy_q |-> (rpt_idx_q == '0))
		else $error("drain index moved while idle");

	// The last marker travels with the final wheel only
	a_last_wheel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.last) |-> (out_data_q.wheel == 3'(WHEEL_COUNT)))
		else $error("last marker on wrong wheel");
`endif

endmodule
